// File: rtl/rmbp_pkg.sv
package rmbp_pkg;

  localparam int unsigned ARGS_W     = 21;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned MAG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_BYTES = 1'b1;

  localparam logic [ARGS_W-1:0] MAX_ARGS_RST      = 21'd65536;
  localparam logic [LEN_W-1:0]  MAX_ARG_BYTES_RST = 32'd536870912;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [MAG_W-1:0] MAG_DIV10_LIMIT = 64'd922337203685477580;
  localparam logic [MAG_W-1:0] SIGN_MAG_LIMIT  = 64'h8000000000000000;

  typedef enum logic [2:0] {
    PH_STAR,
    PH_COUNT,
    PH_DOLLAR,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_STAR,
    ERR_COUNT,
    ERR_DOLLAR,
    ERR_LENGTH,
    ERR_CRLF
  } err_e;

  typedef enum logic [1:0] {
    LINE_MORE,
    LINE_DONE,
    LINE_TOOLONG,
    LINE_BADCR
  } line_e;

  typedef struct packed {
    logic step;
    logic clear;
  } num_ctrl_t;

  typedef struct packed {
    line_e            res;
    logic             ok;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } line_info_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       arg_done;
    logic       cmd_done;
    err_e       error_code;
  } result_t;

endpackage

// File: rtl/rmbp_num.sv
module rmbp_num
  import rmbp_pkg::*;
#(
  parameter int unsigned NUM_FIELD_LIMIT = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  num_ctrl_t  ctrl_i,
  input  logic [7:0] byte_i,
  output line_info_t info_o
);

  localparam int unsigned FLEN_W = $clog2(NUM_FIELD_LIMIT + 1);
  localparam logic [FLEN_W-1:0] FLEN_MAX = FLEN_W'(NUM_FIELD_LIMIT);

  typedef enum logic [1:0] {
    SUB_EMPTY,
    SUB_WS,
    SUB_SIGN,
    SUB_DIGITS
  } sub_e;

  logic [MAG_W-1:0]  mag_q, mag_d;
  logic              neg_q, neg_d;
  sub_e              sub_q, sub_d;
  logic              ovf_q, ovf_d;
  logic [FLEN_W-1:0] flen_q, flen_d;
  logic              cr_q, cr_d;

  logic             is_digit, is_ws, is_sign;
  logic [MAG_W-1:0] prod;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_ws    = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_LF) ||
                    (byte_i == CH_VT) || (byte_i == CH_FF);
  assign is_sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
  assign prod     = (mag_q << 3) + (mag_q << 1) + {{(MAG_W-4){1'b0}}, byte_i[3:0]};

  always_comb begin
    if (cr_q) begin
      info_o.res = (byte_i == CH_LF) ? LINE_DONE : LINE_BADCR;
    end else if (byte_i == CH_CR) begin
      info_o.res = LINE_MORE;
    end else if (flen_q >= FLEN_MAX) begin
      info_o.res = LINE_TOOLONG;
    end else begin
      info_o.res = LINE_MORE;
    end
    info_o.ok  = !ovf_q && ((sub_q == SUB_EMPTY) || (sub_q == SUB_DIGITS));
    info_o.neg = neg_q;
    info_o.mag = mag_q;
  end

  always_comb begin
    mag_d  = mag_q;
    neg_d  = neg_q;
    sub_d  = sub_q;
    ovf_d  = ovf_q;
    flen_d = flen_q;
    cr_d   = cr_q;
    if (ctrl_i.clear) begin
      mag_d  = '0;
      neg_d  = 1'b0;
      sub_d  = SUB_EMPTY;
      ovf_d  = 1'b0;
      flen_d = '0;
      cr_d   = 1'b0;
    end else if (ctrl_i.step && !cr_q) begin
      if (byte_i == CH_CR) begin
        cr_d = 1'b1;
      end else if (flen_q < FLEN_MAX) begin
        flen_d = flen_q + 1'b1;
        if (!ovf_q) begin
          priority if (is_digit) begin
            sub_d = SUB_DIGITS;
            if (mag_q > MAG_DIV10_LIMIT) begin
              ovf_d = 1'b1;
            end else begin
              mag_d = prod;
              if (prod > SIGN_MAG_LIMIT) begin
                ovf_d = 1'b1;
              end
            end
          end else if (is_ws && (sub_q == SUB_EMPTY || sub_q == SUB_WS)) begin
            sub_d = SUB_WS;
          end else if (is_sign && (sub_q == SUB_EMPTY || sub_q == SUB_WS)) begin
            neg_d = (byte_i == CH_MINUS);
            sub_d = SUB_SIGN;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q  <= '0;
      neg_q  <= 1'b0;
      sub_q  <= SUB_EMPTY;
      ovf_q  <= 1'b0;
      flen_q <= '0;
      cr_q   <= 1'b0;
    end else begin
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      sub_q  <= sub_d;
      ovf_q  <= ovf_d;
      flen_q <= flen_d;
      cr_q   <= cr_d;
    end
  end

endmodule

// File: rtl/rmbp_seq.sv
module rmbp_seq
  import rmbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  line_info_t        line_i,
  input  logic [ARGS_W-1:0] max_args_i,
  input  logic [LEN_W-1:0]  max_arg_bytes_i,
  output num_ctrl_t         num_o,
  output result_t           res_o
);

  phase_e            phase_q, phase_d;
  err_e              err_q, err_d;
  logic [ARGS_W-1:0] args_q, args_d;
  logic [LEN_W-1:0]  pay_q, pay_d;
  logic [1:0]        trl_q, trl_d;

  logic              live;
  logic [ARGS_W-1:0] args_dec;
  logic [LEN_W-1:0]  pay_dec;
  logic              count_ok, len_ok;

  assign live     = step_i && (err_q == ERR_NONE);
  assign args_dec = (args_q != '0) ? args_q - 1'b1 : args_q;
  assign pay_dec  = (pay_q != '0) ? pay_q - 1'b1 : pay_q;
  assign count_ok = line_i.ok && (line_i.neg || (line_i.mag <= MAG_W'(max_args_i)));
  assign len_ok   = line_i.ok && (line_i.neg ? (line_i.mag == '0)
                                             : (line_i.mag <= MAG_W'(max_arg_bytes_i)));

  always_comb begin
    phase_d          = phase_q;
    err_d            = err_q;
    args_d           = args_q;
    pay_d            = pay_q;
    trl_d            = trl_q;
    num_o.step       = 1'b0;
    num_o.clear      = 1'b0;
    res_o.data_byte  = '0;
    res_o.data_valid = 1'b0;
    res_o.arg_done   = 1'b0;
    res_o.cmd_done   = 1'b0;
    if (live) begin
      unique case (phase_q)
        PH_STAR: begin
          if (byte_i == CH_STAR) begin
            num_o.clear = 1'b1;
            phase_d     = PH_COUNT;
          end else begin
            err_d = ERR_STAR;
          end
        end
        PH_COUNT: begin
          num_o.step = 1'b1;
          unique case (line_i.res)
            LINE_TOOLONG: err_d = ERR_COUNT;
            LINE_BADCR:   err_d = ERR_CRLF;
            LINE_DONE: begin
              if (!count_ok) begin
                err_d = ERR_COUNT;
              end else if (line_i.neg || line_i.mag == '0) begin
                res_o.cmd_done = 1'b1;
                phase_d        = PH_STAR;
              end else begin
                args_d  = line_i.mag[ARGS_W-1:0];
                phase_d = PH_DOLLAR;
              end
            end
            LINE_MORE: ;
            default: ;
          endcase
        end
        PH_DOLLAR: begin
          if (byte_i == CH_DOLLAR) begin
            num_o.clear = 1'b1;
            phase_d     = PH_LENGTH;
          end else begin
            err_d = ERR_DOLLAR;
          end
        end
        PH_LENGTH: begin
          num_o.step = 1'b1;
          unique case (line_i.res)
            LINE_TOOLONG: err_d = ERR_LENGTH;
            LINE_BADCR:   err_d = ERR_CRLF;
            LINE_DONE: begin
              if (!len_ok) begin
                err_d = ERR_LENGTH;
              end else begin
                pay_d   = line_i.mag[LEN_W-1:0];
                trl_d   = 2'd2;
                phase_d = (line_i.mag[LEN_W-1:0] != '0) ? PH_PAYLOAD : PH_TRAILER;
              end
            end
            LINE_MORE: ;
            default: ;
          endcase
        end
        PH_PAYLOAD: begin
          res_o.data_byte  = byte_i;
          res_o.data_valid = 1'b1;
          pay_d            = pay_dec;
          if (pay_dec == '0) begin
            phase_d = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          if (trl_q > 2'd1) begin
            trl_d = trl_q - 1'b1;
          end else begin
            trl_d          = '0;
            res_o.arg_done = 1'b1;
            args_d         = args_dec;
            if (args_dec == '0) begin
              res_o.cmd_done = 1'b1;
              phase_d        = PH_STAR;
            end else begin
              phase_d = PH_DOLLAR;
            end
          end
        end
        default: phase_d = PH_STAR;
      endcase
    end
    res_o.error_code = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STAR;
      err_q   <= ERR_NONE;
      args_q  <= '0;
      pay_q   <= '0;
      trl_q   <= '0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      args_q  <= args_d;
      pay_q   <= pay_d;
      trl_q   <= trl_d;
    end
  end

endmodule

// File: rtl/resp_multibulk_parser.sv
// Multibulk request parser: one raw request byte in, one result beat out.
// Input stream s_axis carries one request byte per beat. Output stream
// m_axis returns exactly one beat per input beat: the payload byte with
// its flags, argument end, request end (tlast) and the error code.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) set the argument
// count limit (index 0) and the argument length limit (index 1); write
// them only while the parser is idle.
// Each input beat passes through the input register, then the parse logic
// feeding the result register.
// Throughput: 1 beat per cycle when not stalled; the 64-bit multiply-by-ten
// accumulate of the count and length lines sits in the single parse stage.
// Reset: both stages empty, parser waits for '*', no error, limits return
// to 65536 arguments and 2^29 bytes.
// Stall: while m_axis_tready is low a full result register holds its beat;
// one more beat still enters the input register, then s_axis_tready drops.
// An error is sticky until reset; every later beat carries its code.
module resp_multibulk_parser
  import rmbp_pkg::*;
#(
  parameter int unsigned NUM_FIELD_LIMIT = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] byte_req
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] data_byte
  output logic [4:0]            m_axis_tuser,   // [0] data_valid, [1] arg_done, [4:2] error_code
  output logic                  m_axis_tlast,   // cmd_done
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic              in_v_q, in_v_d;
  logic [7:0]        in_byte_q;
  logic              out_v_q, out_v_d;
  result_t           out_q;
  logic [ARGS_W-1:0] max_args_q;
  logic [LEN_W-1:0]  max_arg_bytes_q;

  logic       out_free, fire, s_fire;
  num_ctrl_t  num_ctrl;
  line_info_t line_info;
  result_t    res;

  assign out_free      = !out_v_q || m_axis_tready;
  assign fire          = in_v_q && out_free;
  assign s_axis_tready = !in_v_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  rmbp_num #(
    .NUM_FIELD_LIMIT(NUM_FIELD_LIMIT)
  ) u_num (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(num_ctrl),
    .byte_i(in_byte_q),
    .info_o(line_info)
  );

  rmbp_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .byte_i         (in_byte_q),
    .line_i         (line_info),
    .max_args_i     (max_args_q),
    .max_arg_bytes_i(max_arg_bytes_q),
    .num_o          (num_ctrl),
    .res_o          (res)
  );

  always_comb begin
    in_v_d = in_v_q;
    if (s_fire) begin
      in_v_d = 1'b1;
    end else if (fire) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (fire) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q          <= 1'b0;
      out_v_q         <= 1'b0;
      max_args_q      <= MAX_ARGS_RST;
      max_arg_bytes_q <= MAX_ARG_BYTES_RST;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_ARGS:      max_args_q      <= cfg_data_i[ARGS_W-1:0];
          CFG_MAX_ARG_BYTES: max_arg_bytes_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.data_byte;
  assign m_axis_tuser  = {out_q.error_code, out_q.arg_done, out_q.data_valid};
  assign m_axis_tlast  = out_q.cmd_done;

`ifndef SYNTHESIS
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[4:2] != 3'd0) |->
      (m_axis_tuser[1:0] == 2'b00 && !m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("error beat carries payload or end flags");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register is empty");

  a_fire_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("parsed beat did not reach the result register");
`endif

endmodule

// File: sim/resp_multibulk_parser_tb.sv
module resp_multibulk_parser_tb;
  import rmbp_pkg::*;

  localparam int unsigned FIELD_LIMIT = 32;
  localparam logic [7:0] STRAY_BYTE = 8'h23;

  typedef enum int unsigned {
    BRK_NOT_STAR,
    BRK_LONG_COUNT,
    BRK_OVERFLOW,
    BRK_COUNT_RANGE,
    BRK_NOT_DOLLAR,
    BRK_NEG_LENGTH,
    BRK_LENGTH_RANGE,
    BRK_CR_NO_LF,
    BRK_JUNK_COUNT
  } broken_e;

  class parse_tracker;
    logic [ARGS_W-1:0] max_args;
    logic [LEN_W-1:0]  max_arg_bytes;
    phase_e            phase;
    logic [MAG_W-1:0]  mag;
    bit                neg;
    bit [1:0]          subph;
    bit                ovf;
    int unsigned       flen;
    bit                cr;
    logic [ARGS_W-1:0] args_left;
    logic [LEN_W-1:0]  payload_left;
    logic [1:0]        trailer_left;
    err_e              err;
    result_t           pending_beats[$];
    int unsigned       failures;
    int unsigned       n_bytes, n_reqs, n_args, n_payload;

    function new();
      max_args      = MAX_ARGS_RST;
      max_arg_bytes = MAX_ARG_BYTES_RST;
      phase         = PH_STAR;
      clear_line();
      args_left     = '0;
      payload_left  = '0;
      trailer_left  = '0;
      err           = ERR_NONE;
      failures      = 0;
      n_bytes       = 0;
      n_reqs        = 0;
      n_args        = 0;
      n_payload     = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_MAX_ARGS) max_args = value[ARGS_W-1:0];
      else if (idx == CFG_MAX_ARG_BYTES) max_arg_bytes = value[LEN_W-1:0];
    endfunction

    function void clear_line();
      mag   = '0;
      neg   = 0;
      subph = 0;
      ovf   = 0;
      flen  = 0;
      cr    = 0;
    endfunction

    function bit number_ok();
      return !ovf && (subph == 0 || subph == 3);
    endfunction

    function line_e take_line_byte(logic [7:0] b);
      if (cr) return (b == CH_LF) ? LINE_DONE : LINE_BADCR;
      if (b == CH_CR) begin
        cr = 1;
        return LINE_MORE;
      end
      if (flen >= FIELD_LIMIT) return LINE_TOOLONG;
      flen++;
      if (ovf) return LINE_MORE;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        if (mag > MAG_DIV10_LIMIT) begin
          ovf = 1;
        end else begin
          mag = mag * 10 + (b - CH_ZERO);
          if (mag > SIGN_MAG_LIMIT) ovf = 1;
        end
        subph = 3;
      end else if ((b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF)
                   && subph <= 1) begin
        subph = 1;
      end else if ((b == CH_PLUS || b == CH_MINUS) && subph <= 1) begin
        neg   = (b == CH_MINUS);
        subph = 2;
      end else begin
        ovf = 1;
      end
      return LINE_MORE;
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      line_e   lr;
      bit      ok;
      r = '0;
      n_bytes++;
      if (err == ERR_NONE) begin
        case (phase)
          PH_STAR: begin
            if (b == CH_STAR) begin
              clear_line();
              phase = PH_COUNT;
            end else begin
              err = ERR_STAR;
            end
          end
          PH_COUNT: begin
            lr = take_line_byte(b);
            if (lr == LINE_TOOLONG) begin
              err = ERR_COUNT;
            end else if (lr == LINE_BADCR) begin
              err = ERR_CRLF;
            end else if (lr == LINE_DONE) begin
              if (!number_ok() || (!neg && mag > {43'd0, max_args})) begin
                err = ERR_COUNT;
              end else if (neg || mag == 0) begin
                r.cmd_done = 1'b1;
                phase = PH_STAR;
              end else begin
                args_left = mag[ARGS_W-1:0];
                phase = PH_DOLLAR;
              end
            end
          end
          PH_DOLLAR: begin
            if (b == CH_DOLLAR) begin
              clear_line();
              phase = PH_LENGTH;
            end else begin
              err = ERR_DOLLAR;
            end
          end
          PH_LENGTH: begin
            lr = take_line_byte(b);
            if (lr == LINE_TOOLONG) begin
              err = ERR_LENGTH;
            end else if (lr == LINE_BADCR) begin
              err = ERR_CRLF;
            end else if (lr == LINE_DONE) begin
              ok = number_ok() && (neg ? (mag == 0) : (mag <= {32'd0, max_arg_bytes}));
              if (!ok) begin
                err = ERR_LENGTH;
              end else begin
                payload_left = mag[LEN_W-1:0];
                trailer_left = 2'd2;
                phase = (payload_left != 0) ? PH_PAYLOAD : PH_TRAILER;
              end
            end
          end
          PH_PAYLOAD: begin
            r.data_byte  = b;
            r.data_valid = 1'b1;
            if (payload_left > 0) payload_left--;
            if (payload_left == 0) phase = PH_TRAILER;
          end
          default: begin
            if (trailer_left > 1) begin
              trailer_left--;
            end else begin
              trailer_left = '0;
              r.arg_done = 1'b1;
              if (args_left > 0) args_left--;
              if (args_left == 0) begin
                r.cmd_done = 1'b1;
                phase = PH_STAR;
              end else begin
                phase = PH_DOLLAR;
              end
            end
          end
        endcase
      end
      r.error_code = err;
      n_payload += r.data_valid;
      n_args    += r.arg_done;
      n_reqs    += r.cmd_done;
      pending_beats.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (pending_beats.size() == 0) begin
        $error("result beat 0x%0h with no request byte pending", got);
        failures++;
        return;
      end
      want = pending_beats.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("data_valid", want.data_valid, got.data_valid);
      compare_field("arg_done", want.arg_done, got.arg_done);
      compare_field("cmd_done", want.cmd_done, got.cmd_done);
      compare_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] byte_req
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // [7:0] data_byte
  logic [4:0]            m_axis_tuser;   // [0] data_valid, [1] arg_done, [4:2] error_code
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  parse_tracker tracker;
  logic [7:0]   req_q[$];
  int           ready_hold = 0;
  bit           gaps_on = 1'b1;

  resp_multibulk_parser #(.NUM_FIELD_LIMIT(FIELD_LIMIT)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (ready_hold > 0) begin
        m_axis_tready <= 1'b0;
        ready_hold--;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_beat(result_t'({m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1],
                                    m_axis_tlast, m_axis_tuser[4:2]}));
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic offer_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_byte(b);
  endtask

  task automatic send_queued();
    while (req_q.size() != 0) offer_byte(req_q.pop_front());
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_limit(idx, value);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  // style 0: bare number, 1: padded with whitespace, sign and zeros, 2: full field width
  task automatic push_num(input logic [MAG_W-1:0] mag, input bit negative, input int style);
    logic [7:0]       digits[$];
    logic [MAG_W-1:0] v;
    logic [MAG_W-1:0] rem;
    v = mag;
    do begin
      rem = v % 10;
      digits.push_front(CH_ZERO + rem[7:0]);
      v = v / 10;
    end while (v != 0);
    if (style == 1) begin
      if (mag == 0 && !negative && $urandom_range(0, 3) == 0) begin
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
        return;
      end
      repeat ($urandom_range(0, 2)) req_q.push_back(pick_space());
      if (negative) req_q.push_back(CH_MINUS);
      else if ($urandom_range(0, 2) == 0) req_q.push_back(CH_PLUS);
      repeat ($urandom_range(0, 2)) req_q.push_back(CH_ZERO);
    end else begin
      if (negative) req_q.push_back(CH_MINUS);
      if (style == 2) repeat (FIELD_LIMIT - digits.size() - int'(negative))
        req_q.push_back(CH_ZERO);
    end
    foreach (digits[i]) req_q.push_back(digits[i]);
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
  endtask

  task automatic build_request();
    int unsigned sel;
    int unsigned arg_cap;
    int unsigned len_cap;
    int unsigned nargs;
    int unsigned len;
    req_q.push_back(CH_STAR);
    sel = $urandom_range(0, 15);
    if (tracker.max_args == 0 || sel == 0) begin
      push_num('0, $urandom_range(0, 1), 1);
      return;
    end
    if (sel == 1) begin
      push_num(($urandom_range(0, 1) != 0) ? SIGN_MAG_LIMIT : $urandom_range(1, 99999), 1,
               $urandom_range(0, 1));
      return;
    end
    arg_cap = (tracker.max_args < 6) ? tracker.max_args : 6;
    nargs = $urandom_range(1, arg_cap);
    push_num(nargs, 0, ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1));
    for (int a = 0; a < nargs; a++) begin
      req_q.push_back(CH_DOLLAR);
      len_cap = (tracker.max_arg_bytes < 12) ? tracker.max_arg_bytes : 12;
      len = $urandom_range(0, len_cap);
      push_num(len, len == 0 && $urandom_range(0, 3) == 0,
               ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1));
      repeat (len) req_q.push_back($urandom_range(0, 255));
      repeat (2) req_q.push_back($urandom_range(0, 255));
    end
  endtask

  task automatic build_broken();
    broken_e    kind;
    logic [7:0] b;
    kind = broken_e'($urandom_range(0, BRK_JUNK_COUNT));
    case (kind)
      BRK_NOT_STAR: begin
        b = $urandom_range(0, 255);
        req_q.push_back((b == CH_STAR) ? CH_DOLLAR : b);
      end
      BRK_LONG_COUNT: begin
        req_q.push_back(CH_STAR);
        repeat (FIELD_LIMIT + 1) req_q.push_back(CH_ZERO);
      end
      BRK_OVERFLOW: begin
        req_q.push_back(CH_STAR);
        repeat (20) req_q.push_back(CH_NINE);
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
      end
      BRK_COUNT_RANGE: begin
        req_q.push_back(CH_STAR);
        push_num({43'd0, tracker.max_args} + 64'd1, 0, 1);
      end
      BRK_NOT_DOLLAR: begin
        req_q.push_back(CH_STAR);
        push_num(1, 0, 0);
        req_q.push_back(STRAY_BYTE);
      end
      BRK_NEG_LENGTH: begin
        req_q.push_back(CH_STAR);
        push_num(1, 0, 0);
        req_q.push_back(CH_DOLLAR);
        push_num($urandom_range(1, 9), 1, 1);
      end
      BRK_LENGTH_RANGE: begin
        req_q.push_back(CH_STAR);
        push_num(1, 0, 0);
        req_q.push_back(CH_DOLLAR);
        push_num({32'd0, tracker.max_arg_bytes} + 64'd1, 0, 1);
      end
      BRK_CR_NO_LF: begin
        req_q.push_back(CH_STAR);
        push_num(2, 0, 0);
        req_q.push_back(CH_DOLLAR);
        req_q.push_back(CH_ZERO);
        req_q.push_back(CH_CR);
        req_q.push_back(STRAY_BYTE);
      end
      default: begin
        req_q.push_back(CH_STAR);
        case ($urandom_range(0, 2))
          0:       req_q.push_back(pick_space());
          1:       req_q.push_back(CH_MINUS);
          default: begin
            req_q.push_back(CH_NINE);
            req_q.push_back(STRAY_BYTE);
          end
        endcase
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
      end
    endcase
    repeat (30) req_q.push_back($urandom_range(0, 255));
  endtask

  initial begin
    int unsigned stage;
    int unsigned stage_end;
    tracker       = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MAX_ARGS;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    req_q.push_back(CH_STAR);
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
    req_q.push_back(CH_STAR);
    push_num('0, 1, 0);
    req_q.push_back(CH_STAR);
    push_num(SIGN_MAG_LIMIT, 1, 0);
    req_q.push_back(CH_STAR);
    push_num(2, 0, 0);
    req_q.push_back(CH_DOLLAR);
    push_num('0, 1, 0);
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
    req_q.push_back(CH_DOLLAR);
    push_num(3, 0, 0);
    req_q.push_back(8'h00);
    req_q.push_back(8'hFF);
    req_q.push_back(8'h5A);
    req_q.push_back(8'hA5);
    req_q.push_back(8'h00);
    req_q.push_back(CH_STAR);
    req_q.push_back(CH_TAB);
    req_q.push_back(CH_LF);
    req_q.push_back(CH_VT);
    req_q.push_back(CH_FF);
    req_q.push_back(CH_SPACE);
    req_q.push_back(CH_PLUS);
    push_num(2, 0, 0);
    req_q.push_back(CH_DOLLAR);
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
    req_q.push_back(CH_DOLLAR);
    push_num(2, 0, 2);
    repeat (4) req_q.push_back($urandom_range(0, 255));
    send_queued();

    stage = 0;
    while (stage < 6) begin
      drain_results();
      case (stage)
        0: ;
        1: write_limit(CFG_MAX_ARGS, '0);
        2: begin
          write_limit(CFG_MAX_ARGS, 32'd1048576);
          write_limit(CFG_MAX_ARG_BYTES, '0);
        end
        3: begin
          write_limit(CFG_MAX_ARGS, 32'hFFE0_0004);
          write_limit(CFG_MAX_ARG_BYTES, 32'hFFFF_FFFF);
        end
        4: begin
          write_limit(CFG_MAX_ARGS, 32'd3);
          write_limit(CFG_MAX_ARG_BYTES, 32'd5);
        end
        default: begin
          write_limit(CFG_MAX_ARGS, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 1048576) : $urandom_range(1, 8));
          write_limit(CFG_MAX_ARG_BYTES, ($urandom_range(0, 3) == 0) ?
                      $urandom : $urandom_range(0, 16));
        end
      endcase
      @(posedge clk_i);
      gaps_on = (stage != 3);
      if (stage == 4) ready_hold = 60;
      stage_end = tracker.n_bytes + 60;
      while (tracker.n_bytes < stage_end) begin
        build_request();
        send_queued();
      end
      stage++;
    end

    drain_results();
    @(posedge clk_i);
    gaps_on = 1'b1;
    build_broken();
    send_queued();
    drain_results();
    repeat (16) @(posedge clk_i);

    $display("Checked %0d request bytes: %0d requests, %0d arguments, %0d payload bytes",
             tracker.n_bytes, tracker.n_reqs, tracker.n_args, tracker.n_payload);
    $display("Ran %0d limit settings, ending on sticky error %s", stage, tracker.err.name());
    if (tracker.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
